[design/nearest_centroid_assign_defines.svh]
// Assertion macros shared by the checker of the nearest-centroid assignment block.
// No dependencies; include by bare file name.
`ifndef NEAREST_CENTROID_ASSIGN_DEFINES_SVH
`define NEAREST_CENTROID_ASSIGN_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NCA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest_centroid_assign: assertion failed");

// Next-cycle implication, disabled during reset.
`define NCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest_centroid_assign: assertion failed");

`endif

[design/nca_pkg.sv]
// Package of the nearest-centroid assignment block: sizes, operation codes,
// the cell control word and the token passed along the cell chain.
package nca_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_FEATURES = 16;
  localparam longint MAX_ITEMS = 65535;

  localparam int VAL_W  = 16;
  localparam int DIST_W = 36;
  localparam int CNT_W  = 16;
  localparam int SQ_W   = 2 * VAL_W;
  localparam int CIDX_W = 4;
  localparam int FIDX_W = 4;

  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PW = $clog2(MAX_FEATURES + 1);

  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  COUNT_CAP =
      CNT_W'((MAX_ITEMS < 65535) ? MAX_ITEMS : 65535);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_FEATURE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic              rd_en;
    logic [FW-1:0]     rd_addr;
    logic [FW-1:0]     wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              acc_en;
    logic              acc_clr;
    logic              cnt_clr;
    logic [VAL_W-1:0]  feat;
  } cell_ctrl_t;

  // Best candidate so far, handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [CW-1:0]     idx;
    logic [DIST_W-1:0] dist_sq;
    logic [CNT_W-1:0]  cnt;
  } token_t;

endpackage

[design/nca_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/nca_cell.sv]
// One centroid cell: coordinate RAM, squared-distance accumulator, member
// count, and one stage of the nearest-centroid compare chain. Uses nca_pkg, nca_ram.
module nca_cell
  import nca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       wr_en,
  input  logic       inc,
  input  logic       active,
  input  logic [CW-1:0] cell_idx,
  input  token_t     tok_in,
  output token_t     tok_out
);

  logic [VAL_W-1:0]  coord;
  logic signed [VAL_W:0] diff;
  logic [VAL_W-1:0]  abs_diff;
  logic [SQ_W-1:0]   sq;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  token_t            tok_r, tok_nxt;

  nca_ram #(.WIDTH(VAL_W), .DEPTH(MAX_FEATURES)) u_coords (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ctrl.wr_addr),
    .wr_data (ctrl.wr_data),
    .rd_en   (ctrl.rd_en),
    .rd_addr (ctrl.rd_addr),
    .rd_data (coord)
  );

  always_comb begin
    diff     = $signed({coord[VAL_W-1], coord}) - $signed({ctrl.feat[VAL_W-1], ctrl.feat});
    abs_diff = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    sq       = abs_diff * abs_diff;
    sum      = {1'b0, acc_r} + (DIST_W+1)'(sq);
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_en) begin
      acc_nxt = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.cnt_clr) begin
      cnt_nxt = '0;
    end else if (inc && (cnt_r < COUNT_CAP)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Strictly-less keeps the earlier (lower-index) cell on ties.
  always_comb begin
    tok_nxt = tok_in;
    if (active && (!tok_in.found || (acc_r < tok_in.dist_sq))) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.idx     = cell_idx;
      tok_nxt.dist_sq = acc_r;
      tok_nxt.cnt     = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;

endmodule

[design/nearest_centroid_assign.sv]
// Top level of the nearest-centroid assignment block: controller, active mask,
// output register and the chain of centroid cells. Uses nca_pkg, nca_cell.
//
//  channel | direction | handshake          | words
//  in_     | input     | in_valid/in_stall  | load, feature or clear operation
//  out_    | output    | out_valid/out_stall| one result per item
//  cfg_    | input     | cfg_valid/cfg_ready| active mask write
//
// Load, clear and unused operations are done in the cycle that accepts them; a
// feature is read from the RAM, then squared and accumulated in every cell at once.
// After the last feature of an item the compare token ripples down the cell chain
// (ST_SCAN) and the result is written once the output register is free (ST_EMIT).
// Reset clears accumulators, member counts and the feature position; coordinates
// are not cleared. A result waits in the output register while out_stall is high.
module nearest_centroid_assign
  import nca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [CIDX_W-1:0]   in_centroid_index,
  input  logic [FIDX_W-1:0]   in_feature_index,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                in_last_feature,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CIDX_W-1:0]   out_nearest_cluster,
  output logic [DIST_W-1:0]   out_nearest_distance_sq,
  output logic [CNT_W-1:0]    out_cluster_members,
  output logic                out_no_active,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_active_mask
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic              last_r, last_nxt;
  logic [VAL_W-1:0]  feat_r, feat_nxt;
  logic [15:0]       mask_r;

  logic                out_valid_r, out_valid_nxt;
  logic [CIDX_W-1:0]   out_cluster_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_none_r;

  logic              accept;
  op_t               op;
  logic              room;
  logic              emit;
  logic              load_ok;
  cell_ctrl_t        ctrl;
  logic [MAX_CLUSTERS-1:0] wr_en_vec;
  logic [MAX_CLUSTERS-1:0] inc_vec;
  token_t            tok [MAX_CLUSTERS+1];
  token_t            best;
  logic [CNT_W-1:0]  best_cnt;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign op        = op_t'(in_operation);
  assign room      = (pos_r < PW'(MAX_FEATURES));
  assign emit      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign load_ok   = (32'(in_centroid_index) < MAX_CLUSTERS)
                  && (32'(in_feature_index) < MAX_FEATURES);
  assign best      = tok[MAX_CLUSTERS];
  assign best_cnt  = (best.cnt < COUNT_CAP) ? best.cnt + CNT_W'(1) : best.cnt;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    scan_nxt  = scan_r;
    last_nxt  = last_r;
    feat_nxt  = feat_r;
    ctrl      = '0;
    ctrl.rd_addr = pos_r[FW-1:0];
    ctrl.wr_addr = in_feature_index[FW-1:0];
    ctrl.wr_data = in_value;
    ctrl.feat    = feat_r;
    wr_en_vec = '0;
    inc_vec   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD: begin
              for (int c = 0; c < MAX_CLUSTERS; c++) begin
                wr_en_vec[c] = load_ok && (32'(in_centroid_index) == c);
              end
            end
            OP_CLEAR: begin
              ctrl.cnt_clr = 1'b1;
            end
            OP_FEATURE: begin
              last_nxt = in_last_feature;
              scan_nxt = '0;
              if (room) begin
                ctrl.rd_en = 1'b1;
                feat_nxt   = in_value;
                pos_nxt    = pos_r + PW'(1);
                state_nxt  = ST_ACC;
              end else if (in_last_feature) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ACC: begin
        ctrl.acc_en = 1'b1;
        state_nxt   = last_r ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_r == CW'(MAX_CLUSTERS - 1)) begin
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      ST_EMIT: begin
        if (emit) begin
          for (int c = 0; c < MAX_CLUSTERS; c++) begin
            inc_vec[c] = best.found && (32'(best.idx) == c);
          end
          ctrl.acc_clr = 1'b1;
          pos_nxt      = '0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      scan_r      <= '0;
      last_r      <= 1'b0;
      mask_r      <= 16'hFFFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      scan_r      <= scan_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_active_mask;
      end
    end
    feat_r <= feat_nxt;
    if (emit) begin
      out_none_r    <= !best.found;
      out_cluster_r <= best.found ? CIDX_W'(best.idx) : '0;
      out_dist_r    <= best.found ? best.dist_sq : '0;
      out_cnt_r     <= best.found ? best_cnt : '0;
    end
  end

  assign tok[0] = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    nca_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .wr_en    (wr_en_vec[g]),
      .inc      (inc_vec[g]),
      .active   (mask_r[g]),
      .cell_idx (CW'(g)),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  assign out_valid               = out_valid_r;
  assign out_nearest_cluster     = out_cluster_r;
  assign out_nearest_distance_sq = out_dist_r;
  assign out_cluster_members     = out_cnt_r;
  assign out_no_active           = out_none_r;

endmodule

[design/nca_checker.sv]
// Port-level checker for nearest_centroid_assign, bound to the top level.
// Uses nca_pkg and the assertion macros in nearest_centroid_assign_defines.svh.
`include "nearest_centroid_assign_defines.svh"

module nca_checker
  import nca_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [1:0]          in_operation,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CIDX_W-1:0]   out_nearest_cluster,
  input logic [DIST_W-1:0]   out_nearest_distance_sq,
  input logic [CNT_W-1:0]    out_cluster_members,
  input logic                out_no_active
);

  // An empty mask reports nothing but the flag.
  `NCA_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && out_no_active,
    (out_nearest_cluster == '0) && (out_nearest_distance_sq == '0)
    && (out_cluster_members == '0))

  // A real assignment always counts at least the item itself.
  `NCA_ASSERT_NOW(a_members_nonzero, clk, rst_n, out_valid && !out_no_active,
    out_cluster_members != '0)

  // A load is done in the cycle that accepts it, so the input is open again right after.
  `NCA_ASSERT_NEXT(a_load_one_cycle, clk, rst_n,
    in_valid && !in_stall && (in_operation == OP_LOAD), !in_stall)

  // A stalled result word holds.
  `NCA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_nearest_cluster) && $stable(out_nearest_distance_sq)
    && $stable(out_cluster_members) && $stable(out_no_active))

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_stall                (in_stall),
  .in_operation            (in_operation),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_nearest_cluster     (out_nearest_cluster),
  .out_nearest_distance_sq (out_nearest_distance_sq),
  .out_cluster_members     (out_cluster_members),
  .out_no_active           (out_no_active)
);
